// ===== src/bdm_pkg.sv =====
package bdm_pkg;
  localparam int MaxWidthDefault = 2048;
  localparam int LineCount = 5;
  localparam int Win = 6;
  localparam int SampleW = 12;
  localparam int RowW = 12;
  localparam int ColW = 11;
  localparam int CfgW = 12;
  localparam int SumW = 18;
  localparam logic [CfgW-1:0] WidthReset = 12'd2048;
  localparam logic [CfgW-1:0] HeightReset = 12'd1080;
  localparam logic [0:0] RegWidth = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef logic [SampleW-1:0] sample_t;

  typedef struct packed {
    logic [RowW-1:0] pixel_row;
    logic [ColW-1:0] pixel_col;
    logic [7:0]      blue;
    logic [7:0]      green;
    logic [7:0]      red;
    logic            last_of_quad;
  } pixel_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } quad_pos_t;

  function automatic logic [7:0] to8(input logic signed [SumW-1:0] v);
    logic [7:0] res;
    if (v < 0) res = 8'd0;
    else if (v > 18'sd4095) res = 8'hff;
    else res = v[11:4];
    return res;
  endfunction
endpackage

// ===== src/bdm_stream_if.sv =====
interface bdm_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/bdm_ram.sv =====
module bdm_ram #(
  parameter int Width = 12,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/bdm_cell.sv =====
module bdm_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic [6*12-1:0]      col_in,
  output logic [6*12-1:0]      col_out
);
  always_ff @(posedge clk) begin
    if (rst) col_out <= '0;
    else if (shift) col_out <= col_in;
  end
endmodule

// ===== src/bdm_kernel.sv =====
module bdm_kernel (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bdm_pkg::quad_pos_t pos,
  input  logic [36*12-1:0] win,
  input  logic           out_ready,
  output logic           busy,
  output logic           out_valid,
  output bdm_pkg::pixel_t out_pix
);
  import bdm_pkg::*;

  logic signed [SumW-1:0] g1, b1, r2, b2, r3, b3, r4, g4;
  logic signed [SumW-1:0] rc_s, bc_s, g01_s, g10_s;
  pixel_t q [4];
  logic [2:0] cnt;
  logic [1:0] idx;

  function automatic logic signed [SumW-1:0] p(input logic [36*12-1:0] w,
                                               input int dr, input int dc);
    return SumW'({6'd0, w[((2+dr)*6+(2+dc))*12 +: 12]});
  endfunction

  logic signed [SumW-1:0] rfar, bfar, s1, s2;
  always_comb begin
    rfar = p(win,-2,0) + p(win,0,-2) + p(win,0,2) + p(win,2,0);
    bfar = p(win,-1,1) + p(win,1,-1) + p(win,1,3) + p(win,3,1);
    g1 = SumW'((4*p(win,0,0) - rfar
                + 2*(p(win,-1,0)+p(win,0,-1)+p(win,0,1)+p(win,1,0))) >>> 3);
    b1 = SumW'((12*p(win,0,0) - 3*rfar
                + 4*(p(win,-1,-1)+p(win,-1,1)+p(win,1,-1)+p(win,1,1))) >>> 4);
    s1 = (p(win,-2,1) + p(win,2,1)) >>> 1;
    r2 = SumW'((4*(p(win,0,0)+p(win,0,2)) - (p(win,-1,0)+p(win,-1,2)+p(win,0,-1)
                + p(win,0,3) + p(win,1,0)+p(win,1,2)) + s1 + 5*p(win,0,1)) >>> 3);
    s2 = (p(win,0,-1) + p(win,0,3)) >>> 1;
    b2 = SumW'((4*(p(win,-1,1)+p(win,1,1)) - (p(win,-2,1)+p(win,-1,0)+p(win,-1,2)
                + p(win,1,0) + p(win,1,2)+p(win,2,1)) + s2 + 5*p(win,0,1)) >>> 3);
    r3 = SumW'((4*(p(win,0,0)+p(win,2,0)) - (p(win,-1,0)+p(win,0,-1)+p(win,0,1)
                + p(win,2,-1) + p(win,2,1)+p(win,3,0)) + ((p(win,1,-2)+p(win,1,2)) >>> 1)
                + 5*p(win,1,0)) >>> 3);
    b3 = SumW'((4*(p(win,1,-1)+p(win,1,1)) - (p(win,0,-1)+p(win,0,1)+p(win,1,-2)
                + p(win,1,2) + p(win,2,-1)+p(win,2,1)) + ((p(win,-1,0)+p(win,3,0)) >>> 1)
                + 5*p(win,1,0)) >>> 3);
    r4 = SumW'((4*(p(win,0,0)+p(win,0,2)+p(win,2,0)+p(win,2,2)) - 3*bfar
                + 12*p(win,1,1)) >>> 4);
    g4 = SumW'((4*p(win,1,1) - bfar
                + 2*(p(win,0,1)+p(win,1,0)+p(win,1,2)+p(win,2,1))) >>> 3);
    rc_s = p(win,0,0);
    bc_s = p(win,1,1);
    g01_s = p(win,0,1);
    g10_s = p(win,1,0);
  end

  assign busy = (cnt != 3'd0);
  assign out_valid = busy;
  assign out_pix = q[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (start) begin
      cnt <= 3'd4;
      idx <= '0;
    end else if (busy && out_ready) begin
      cnt <= cnt - 3'd1;
      idx <= idx + 2'd1;
    end
    if (start) begin
      q[0] <= '{pos.row, pos.col, to8(b1), to8(g1), to8(rc_s), 1'b0};
      q[1] <= '{pos.row, pos.col + ColW'(1), to8(b2), to8(g01_s), to8(r2), 1'b0};
      q[2] <= '{pos.row + RowW'(1), pos.col, to8(b3), to8(g10_s), to8(r3), 1'b0};
      q[3] <= '{pos.row + RowW'(1), pos.col + ColW'(1), to8(bc_s), to8(g4), to8(r4),
                1'b1};
    end
  end
endmodule

// ===== src/bayer_rggb_demosaic.sv =====
// channel | direction | payload
// in      | sink      | raw_sample, frame_start
// out     | source    | pixel_row, pixel_col, blue, green, red, last_of_quad
// cfg     | write     | cfg_we, cfg_index, cfg_data
// One sample enters per cycle. A beat that completes a quad waits while an
// earlier quad is in the two stages before the kernel or in the kernel; the
// kernel loads once that beat has passed the stage 1 registers and start_q, and
// its four pixels then leave in turn, each held by an output stall. Line-store
// reads are registered in the ram. Reset is synchronous; the line store is not
// cleared.
module bayer_rggb_demosaic
  import bdm_pkg::*;
#(
  parameter int MaxWidth = MaxWidthDefault
) (
  input  logic clk,
  input  logic rst,
  bdm_stream_if.sink   in_ch,
  bdm_stream_if.source out_ch,
  input  logic                     cfg_we,
  input  logic [0:0]               cfg_index,
  input  logic [bdm_pkg::CfgW-1:0] cfg_data
);
  localparam int AddrW = $clog2(MaxWidth);
  localparam int CW = (AddrW > ColW) ? AddrW + 1 : ColW + 1;

  logic [CfgW-1:0] image_width, image_height;
  logic [CW-1:0] col_count, c, w;
  logic [RowW-1:0] row_count, r, h;
  logic [AddrW-1:0] ci;
  logic [2:0] rmod, rmod_count;
  logic acc;
  logic fire_in, quad_pending;
  logic start_q;

  // stage 1 registers
  logic s1_valid, s1_fire;
  logic [2:0] s1_rmod;
  sample_t s1_sample;
  quad_pos_t s1_pos;
  logic [LineCount*12-1:0] rd;
  logic [6*12-1:0] newcol;
  logic [36*12-1:0] win;
  logic kbusy;

  always_comb begin
    logic [CfgW-1:0] wt, ht;
    wt = image_width & ~CfgW'(1);
    if (wt < 12'd8) wt = 12'd8;
    w = CW'(wt);
    if (w > CW'(MaxWidth & ~1)) w = CW'(MaxWidth & ~1);
    ht = image_height & ~CfgW'(1);
    if (ht < 12'd6) ht = 12'd6;
    h = ht;
  end

  assign r = in_ch.data.frame_start ? '0 : row_count;
  assign c = in_ch.data.frame_start ? '0 : col_count;
  assign rmod = in_ch.data.frame_start ? 3'd0 : rmod_count;
  assign ci = (c < CW'(MaxWidth)) ? c[AddrW-1:0] : AddrW'(MaxWidth - 1);
  assign fire_in = r[0] && c[0] && r >= RowW'(5) && c >= CW'(5) && r < h && c < w;
  assign quad_pending = kbusy || (s1_valid && s1_fire) || start_q;
  assign in_ch.ready = !(fire_in && quad_pending);
  assign acc = in_ch.valid && in_ch.ready;

  for (genvar k = 0; k < LineCount; k++) begin : g_line
    bdm_ram #(.Width(12), .Depth(MaxWidth)) u_ram (
      .clk(clk), .we(acc && rmod == 3'(k)), .waddr(ci),
      .wdata(in_ch.data.raw_sample), .raddr(ci), .rdata(rd[k*12 +: 12])
    );
  end

  always_comb begin
    for (int k = 0; k < LineCount; k++) begin
      int s;
      s = int'(s1_rmod) + k;
      if (s >= 5) s = s - 5;
      newcol[k*12 +: 12] = rd[s*12 +: 12];
    end
    newcol[LineCount*12 +: 12] = s1_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WidthReset;
      image_height <= HeightReset;
      col_count <= '0;
      row_count <= '0;
      rmod_count <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegWidth: image_width <= cfg_data;
          RegHeight: image_height <= cfg_data;
          default: ;
        endcase
      end
      s1_valid <= acc;
      if (acc) begin
        if (c >= w - CW'(1)) begin
          col_count <= '0;
          row_count <= (r >= h - RowW'(1)) ? '0 : r + RowW'(1);
          rmod_count <= (r >= h - RowW'(1)) ? 3'd0 : (rmod == 3'd4 ? 3'd0 : rmod + 3'd1);
        end else begin
          col_count <= c + CW'(1);
          row_count <= r;
          rmod_count <= rmod;
        end
      end
    end
    if (acc) begin
      s1_sample <= in_ch.data.raw_sample;
      s1_rmod <= rmod;
      s1_fire <= fire_in;
      s1_pos.row <= r - RowW'(3);
      s1_pos.col <= ColW'(c - CW'(3));
    end
  end

  // rows stored by r mod 5; row r-5+k lives at (rmod+k) mod 5 before overwrite
  for (genvar j = 0; j < Win; j++) begin : g_cell
    logic [6*12-1:0] cin;
    if (j == Win - 1) begin : g_last
      assign cin = newcol;
    end else begin : g_mid
      assign cin = g_cell[j+1].cout;
    end
    logic [6*12-1:0] cout;
    bdm_cell u_cell (.clk(clk), .rst(rst), .shift(s1_valid), .col_in(cin), .col_out(cout));
    for (genvar k = 0; k < Win; k++) begin : g_k
      assign win[(k*6+j)*12 +: 12] = cout[k*12 +: 12];
    end
  end

  quad_pos_t pos_q;
  pixel_t opix;
  always_ff @(posedge clk) begin
    if (rst) start_q <= 1'b0;
    else start_q <= s1_valid && s1_fire;
    pos_q <= s1_pos;
  end

  bdm_kernel u_kernel (
    .clk(clk), .rst(rst), .start(start_q), .pos(pos_q), .win(win),
    .out_ready(out_ch.ready), .busy(kbusy), .out_valid(out_ch.valid), .out_pix(opix)
  );
  assign out_ch.data = opix;
endmodule
